// ----- rtl/bounded_data_memory_access_unit_defines.svh -----
// Assertion macros for the bounded data memory access unit.
// Used by the checker; expects clk and rst in scope.
`ifndef BOUNDED_DATA_MEMORY_ACCESS_UNIT_DEFINES_SVH
`define BOUNDED_DATA_MEMORY_ACCESS_UNIT_DEFINES_SVH

// Property checked outside reset.
`define BDMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked during and after reset.
`define BDMA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/bdma_pkg.sv -----
// Shared types and codes of the bounded data memory access unit.
// No dependencies.
package bdma_pkg;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_OOB        = 2'd1,
    ST_MISALIGNED = 2'd2
  } bdma_status_t;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_STORE = 1'b1
  } bdma_cmd_t;

  typedef enum logic [1:0] {
    SZ_BYTE   = 2'd0,
    SZ_HALF   = 2'd1,
    SZ_WORD   = 2'd2,
    SZ_DOUBLE = 2'd3
  } bdma_size_t;

  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_BYTES = 1'b1;

  localparam logic [31:0] BASE_RESET  = 32'd0;
  localparam logic [12:0] BYTES_RESET = 13'd4096;

  typedef struct packed {
    bdma_cmd_t    cmd;
    bdma_size_t   size;
    logic         sext;
    bdma_status_t status;
    logic [2:0]   lane;
    logic [63:0]  data;
  } bdma_req_t;

  function automatic logic [3:0] size_bytes(bdma_size_t s);
    return 4'd1 << s;
  endfunction

endpackage

// ----- rtl/bdma_ram.sv -----
// Generic single-port RAM, read-first, registered read.
// No dependencies.
module bdma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                      wdata,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/bdma_queue.sv -----
// Two-entry request queue between front and back.
// No dependencies.
module bdma_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  output logic             head_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/bdma_front.sv -----
// Front end: window registers, request accept, bounds and alignment check.
// Depends on bdma_pkg.
module bdma_front
  import bdma_pkg::*;
#(
  parameter int MEM_BYTES = 4096,
  parameter int ROW_W     = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_data,
  input  logic             req_valid,
  output logic             req_stall,
  input  logic             cmd,
  input  logic [1:0]       access_size,
  input  logic             sign_extend,
  input  logic [31:0]      address,
  input  logic [63:0]      store_data,
  input  logic             busy,
  input  logic             q_full,
  output logic             push,
  output bdma_req_t        push_req,
  output logic [ROW_W-1:0] push_row
);

  logic [31:0] base_address;
  logic [12:0] bytes_in_use;
  logic [32:0] win;
  logic [32:0] limit;
  logic [32:0] end_addr;
  logic [31:0] off;
  logic [3:0]  nbytes;
  logic        oob;
  logic        misaligned;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= BASE_RESET;
      bytes_in_use <= BYTES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE:  base_address <= cfg_data;
        CFG_BYTES: bytes_in_use <= cfg_data[12:0];
        default:   base_address <= base_address;
      endcase
    end
  end

  always_comb begin
    nbytes   = size_bytes(bdma_size_t'(access_size));
    win      = (33'(bytes_in_use) > 33'(MEM_BYTES)) ? 33'(MEM_BYTES) : 33'(bytes_in_use);
    limit    = {1'b0, base_address} + win;
    end_addr = {1'b0, address} + 33'(nbytes);
    oob      = (address < base_address) || (end_addr > limit);
    off      = address - base_address;
    misaligned = (bdma_cmd_t'(cmd) == CMD_LOAD) &&
                 ((off[2:0] & (nbytes[2:0] - 3'd1)) != 3'd0);
  end

  assign req_stall = busy || q_full;
  assign push      = req_valid && !req_stall;

  always_comb begin
    push_req.cmd    = bdma_cmd_t'(cmd);
    push_req.size   = bdma_size_t'(access_size);
    push_req.sext   = sign_extend;
    push_req.status = oob ? ST_OOB : (misaligned ? ST_MISALIGNED : ST_OK);
    push_req.lane   = off[2:0];
    push_req.data   = store_data;
    push_row        = off[ROW_W+2:3];
  end

endmodule

// ----- rtl/bdma_back.sv -----
// Back end: clearing pass, byte-lane memory access, load formatting.
// Depends on bdma_pkg and bdma_ram.
module bdma_back
  import bdma_pkg::*;
#(
  parameter int ROWS  = 512,
  parameter int ROW_W = 9
) (
  input  logic             clk,
  input  logic             rst,
  output logic             busy,
  input  logic             q_valid,
  input  bdma_req_t        q_req,
  input  logic [ROW_W-1:0] q_row,
  output logic             q_pop,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output logic [63:0]      read_data,
  output logic [1:0]       status
);

  logic             clearing;
  logic [ROW_W-1:0] clr_row;
  logic             a_valid;
  bdma_req_t        a_req;
  logic [63:0]      row_data;
  logic [63:0]      shifted;
  logic [63:0]      load_val;
  logic             write_ok;
  logic [3:0]       nbytes;

  assign busy  = clearing;
  assign q_pop = q_valid && !clearing && !a_valid && (!rsp_valid || !rsp_stall);

  assign nbytes   = size_bytes(q_req.size);
  assign write_ok = q_pop && (q_req.cmd == CMD_STORE) && (q_req.status == ST_OK);

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      if (clr_row == ROW_W'(ROWS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_row <= clr_row + 1'b1;
      end
    end
  end

  for (genvar l = 0; l < 8; l++) begin : g_lane
    logic [2:0]       idx;
    logic             we;
    logic [ROW_W-1:0] addr;
    logic [7:0]       wdata;
    logic [63:0]      data_sh;

    always_comb begin
      idx     = 3'(l) - q_req.lane;
      data_sh = q_req.data >> {idx, 3'b000};
      if (clearing) begin
        we    = 1'b1;
        addr  = clr_row;
        wdata = 8'd0;
      end else begin
        we    = write_ok && ({1'b0, idx} < nbytes);
        addr  = (q_req.cmd == CMD_STORE && 3'(l) < q_req.lane) ? q_row + 1'b1 : q_row;
        wdata = data_sh[7:0];
      end
    end

    bdma_ram #(
      .WIDTH(8),
      .DEPTH(ROWS)
    ) u_ram (
      .clk  (clk),
      .we   (we),
      .addr (addr),
      .wdata(wdata),
      .rdata(row_data[8*l +: 8])
    );
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_req <= q_req;
    end
  end

  always_comb begin
    shifted = row_data >> {a_req.lane, 3'b000};
    case (a_req.size)
      SZ_BYTE:   load_val = {{56{a_req.sext & shifted[7]}}, shifted[7:0]};
      SZ_HALF:   load_val = {{48{a_req.sext & shifted[15]}}, shifted[15:0]};
      SZ_WORD:   load_val = {{32{a_req.sext & shifted[31]}}, shifted[31:0]};
      default:   load_val = shifted;
    endcase
    if (a_req.cmd == CMD_STORE || a_req.status != ST_OK) begin
      load_val = 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      a_valid <= q_pop;
      if (a_valid) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid) begin
      read_data <= load_val;
      status    <= a_req.status;
    end
  end

endmodule

// ----- rtl/bounded_data_memory_access_unit.sv -----
// Top level of the bounded data memory access unit.
// Depends on bdma_pkg, bdma_front, bdma_queue, bdma_back.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  cmd access_size sign_extend address store_data
//   rsp      out        rsp_valid / rsp_stall  read_data status
//   cfg      in         cfg_we                 cfg_index cfg_data
//
// An accepted request passes the queue, then the back end, before rsp_valid shows its response.
// The back end does not start a memory access while the last is still in its first step: a row read
// of the byte lanes, then the response register.
// After reset a clearing pass zeroes every memory row; req_stall is high meanwhile.
// A two-entry queue keeps accepting requests while rsp is stalled, until it is full.
module bounded_data_memory_access_unit
  import bdma_pkg::*;
#(
  parameter int MEM_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        cmd,
  input  logic [1:0]  access_size,
  input  logic        sign_extend,
  input  logic [31:0] address,
  input  logic [63:0] store_data,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [63:0] read_data,
  output logic [1:0]  status
);

  localparam int ROWS  = (MEM_BYTES + 7) / 8;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int QW    = $bits(bdma_req_t) + ROW_W;

  logic             busy;
  logic             q_full;
  logic             push;
  bdma_req_t        push_req;
  logic [ROW_W-1:0] push_row;
  logic             q_valid;
  logic             q_pop;
  logic [QW-1:0]    q_head;
  bdma_req_t        q_req;
  logic [ROW_W-1:0] q_row;

  assign {q_req, q_row} = q_head;

  bdma_front #(
    .MEM_BYTES(MEM_BYTES),
    .ROW_W    (ROW_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .cmd        (cmd),
    .access_size(access_size),
    .sign_extend(sign_extend),
    .address    (address),
    .store_data (store_data),
    .busy       (busy),
    .q_full     (q_full),
    .push       (push),
    .push_req   (push_req),
    .push_row   (push_row)
  );

  bdma_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_req, push_row}),
    .full      (q_full),
    .head_valid(q_valid),
    .pop       (q_pop),
    .head_data (q_head)
  );

  bdma_back #(
    .ROWS (ROWS),
    .ROW_W(ROW_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .busy     (busy),
    .q_valid  (q_valid),
    .q_req    (q_req),
    .q_row    (q_row),
    .q_pop    (q_pop),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .read_data(read_data),
    .status   (status)
  );

endmodule

// ----- rtl/bdma_checker.sv -----
// Port-level checks of the bounded data memory access unit, bound to the top level.
// Depends on bdma_pkg and bounded_data_memory_access_unit_defines.svh.
`include "bounded_data_memory_access_unit_defines.svh"

module bdma_checker
  import bdma_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        req_stall,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic [63:0] read_data,
  input logic [1:0]  status
);

  `BDMA_ASSERT_RST(a_clear_after_reset, rst |=> req_stall, "requests taken during clearing pass")

  `BDMA_ASSERT(a_refused_zero, rsp_valid && status != ST_OK |-> read_data == 64'd0, "refused access returned data")

  `BDMA_ASSERT(a_status_code, rsp_valid |-> status == ST_OK || status == ST_OOB || status == ST_MISALIGNED, "undefined status code")

  `BDMA_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(read_data) && $stable(status), "stalled response changed")

endmodule

bind bounded_data_memory_access_unit bdma_checker u_bdma_checker (.*);

// ----- test/tb_bounded_data_memory_access_unit.sv -----
// Testbench for bounded_data_memory_access_unit: directed table, then random loads and
// stores over several window settings, checked against a byte-level shadow of the memory.
// Depends on bdma_pkg and the bounded_data_memory_access_unit RTL.
module tb_bounded_data_memory_access_unit;
  import bdma_pkg::*;

  localparam int MEM_BYTES   = 4096;
  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 300;
  localparam int PLAN_ROWS   = 22;

  typedef struct packed {
    logic [63:0]  data;
    bdma_status_t status;
  } rsp_t;

  typedef struct packed {
    bdma_cmd_t    cmd;
    bdma_size_t   size;
    logic         sext;
    logic [31:0]  addr;
    logic [63:0]  data;
    logic         typed;
    logic [63:0]  want_data;
    bdma_status_t want_status;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_BASE;
  logic [31:0] cfg_data = '0;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic        cmd = CMD_LOAD;
  logic [1:0]  access_size = SZ_BYTE;
  logic        sign_extend = 1'b0;
  logic [31:0] address = '0;
  logic [63:0] store_data = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [63:0] read_data;
  logic [1:0]  status;

  logic [7:0]  shadow_mem [MEM_BYTES];
  logic [31:0] win_base;
  logic [12:0] win_bytes;
  rsp_t        rsp_due [$];
  plan_row_t   plan [PLAN_ROWS];

  int errors = 0;
  int cycles = 0;
  int idle_pct = 20;
  bit hold_rsp_req = 1'b0;
  int n_loads = 0;
  int n_stores = 0;
  int n_oob = 0;
  int n_misaligned = 0;
  int n_settings = 0;

  bounded_data_memory_access_unit #(.MEM_BYTES(MEM_BYTES)) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .cmd         (cmd),
    .access_size (access_size),
    .sign_extend (sign_extend),
    .address     (address),
    .store_data  (store_data),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .read_data   (read_data),
    .status      (status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int window_span();
    return (win_bytes > MEM_BYTES) ? MEM_BYTES : int'(win_bytes);
  endfunction

  // Apply one access to the shadow memory and return its response.
  function automatic rsp_t access_outcome(bdma_cmd_t c, bdma_size_t sz, logic sx,
                                          logic [31:0] a, logic [63:0] d);
    rsp_t        r;
    int          n;
    int          off;
    int          i;
    logic [32:0] last;
    logic [32:0] lim;
    r.data   = '0;
    r.status = ST_OK;
    n        = 1 << sz;
    last     = {1'b0, a} + 33'(n);
    lim      = {1'b0, win_base} + 33'(window_span());
    if (a < win_base || last > lim) begin
      r.status = ST_OOB;
    end else begin
      off = int'(a - win_base);
      if (c == CMD_STORE) begin
        for (i = 0; i < n; i++) shadow_mem[off + i] = d[8*i +: 8];
      end else if (n > 1 && (off % n) != 0) begin
        r.status = ST_MISALIGNED;
      end else begin
        for (i = 0; i < n; i++) r.data[8*i +: 8] = shadow_mem[off + i];
        if (n < 8 && sx && r.data[8*n-1]) begin
          for (i = n; i < 8; i++) r.data[8*i +: 8] = 8'hFF;
        end
      end
    end
    return r;
  endfunction

  // Mostly in-window addresses, biased to low offsets so loads meet earlier stores.
  function automatic logic [31:0] pick_address(bdma_size_t sz);
    longint n;
    longint w;
    longint off;
    int     r;
    n = 1 << sz;
    w = window_span();
    r = $urandom_range(0, 99);
    if (r < 75 && w >= n) begin
      if ($urandom_range(0, 1) == 1) off = $urandom_range(0, int'((w - n > 63) ? 63 : w - n));
      else off = $urandom_range(0, int'(w - n));
      if ($urandom_range(0, 4) != 0) off = off & ~(n - 1);
    end else if (r < 85) begin
      off = w - n + $urandom_range(0, 8);
    end else if (r < 93) begin
      off = -longint'($urandom_range(1, 16));
    end else begin
      return $urandom;
    end
    return win_base + off[31:0];
  endfunction

  task automatic offer(plan_row_t row);
    rsp_t r;
    while ($urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid   <= 1'b1;
    cmd         <= row.cmd;
    access_size <= row.size;
    sign_extend <= row.sext;
    address     <= row.addr;
    store_data  <= row.data;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    r = access_outcome(row.cmd, row.size, row.sext, row.addr, row.data);
    if (row.typed) begin
      r.data   = row.want_data;
      r.status = row.want_status;
    end
    if (row.cmd == CMD_STORE) n_stores++;
    else n_loads++;
    if (r.status == ST_OOB) n_oob++;
    if (r.status == ST_MISALIGNED) n_misaligned++;
    rsp_due.push_back(r);
  endtask

  task automatic drain_rsp();
    req_valid <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_window(logic [31:0] b, logic [12:0] nb);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BASE;
    cfg_data  <= b;
    @(posedge clk);
    win_base  = b;
    cfg_index <= CFG_BYTES;
    cfg_data  <= {19'd0, nb};
    @(posedge clk);
    win_bytes = nb;
    cfg_we    <= 1'b0;
    n_settings++;
  endtask

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("bounded_data_memory_access_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    int held;
    forever begin
      @(posedge clk);
      if (hold_rsp_req) begin
        hold_rsp_req = 1'b0;
        rsp_stall <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < idle_pct);
      end
    end
  end

  initial begin
    rsp_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        if (rsp_due.size() == 0) begin
          $error("response with no request outstanding: read_data %h status %0d",
                 read_data, status);
          errors++;
        end else begin
          want = rsp_due.pop_front();
          if (read_data !== want.data) begin
            $error("read_data: expected %h, got %h", want.data, read_data);
            errors++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    plan_row_t   row;
    int          k;
    int          p;
    int          n_items;
    logic [31:0] nb;
    logic [12:0] nw;

    for (k = 0; k < MEM_BYTES; k++) shadow_mem[k] = 8'h00;
    win_base  = BASE_RESET;
    win_bytes = BYTES_RESET;

    plan = '{
      '{CMD_LOAD,  SZ_DOUBLE, 1'b0, 32'd0,    64'd0, 1'b1, 64'd0, ST_OK},
      '{CMD_STORE, SZ_DOUBLE, 1'b0, 32'd0,    64'h8877_6655_4433_2211, 1'b1, 64'd0, ST_OK},
      '{CMD_LOAD,  SZ_BYTE,   1'b1, 32'd7,    64'd0, 1'b1, 64'hFFFF_FFFF_FFFF_FF88, ST_OK},
      '{CMD_LOAD,  SZ_BYTE,   1'b0, 32'd7,    64'd0, 1'b1, 64'h88, ST_OK},
      '{CMD_LOAD,  SZ_HALF,   1'b1, 32'd6,    64'd0, 1'b0, 64'd0, ST_OK},
      '{CMD_LOAD,  SZ_WORD,   1'b1, 32'd4,    64'd0, 1'b0, 64'd0, ST_OK},
      '{CMD_LOAD,  SZ_DOUBLE, 1'b1, 32'd0,    64'd0, 1'b1, 64'h8877_6655_4433_2211, ST_OK},
      '{CMD_LOAD,  SZ_HALF,   1'b0, 32'd1,    64'd0, 1'b1, 64'd0, ST_MISALIGNED},
      '{CMD_LOAD,  SZ_WORD,   1'b1, 32'd2,    64'd0, 1'b1, 64'd0, ST_MISALIGNED},
      '{CMD_LOAD,  SZ_DOUBLE, 1'b0, 32'd4,    64'd0, 1'b1, 64'd0, ST_MISALIGNED},
      '{CMD_STORE, SZ_WORD,   1'b0, 32'd3,    64'h0123_4567_8000_00F0, 1'b1, 64'd0, ST_OK},
      '{CMD_LOAD,  SZ_DOUBLE, 1'b0, 32'd0,    64'd0, 1'b0, 64'd0, ST_OK},
      '{CMD_STORE, SZ_DOUBLE, 1'b0, 32'd4088, '1,    1'b1, 64'd0, ST_OK},
      '{CMD_LOAD,  SZ_DOUBLE, 1'b0, 32'd4088, 64'd0, 1'b1, '1,    ST_OK},
      '{CMD_LOAD,  SZ_DOUBLE, 1'b0, 32'd4089, 64'd0, 1'b1, 64'd0, ST_OOB},
      '{CMD_LOAD,  SZ_BYTE,   1'b0, 32'd4096, 64'd0, 1'b1, 64'd0, ST_OOB},
      '{CMD_STORE, SZ_WORD,   1'b0, 32'd4094, 64'd0, 1'b1, 64'd0, ST_OOB},
      '{CMD_LOAD,  SZ_HALF,   1'b0, 32'd4094, 64'd0, 1'b1, 64'hFFFF, ST_OK},
      '{CMD_STORE, SZ_BYTE,   1'b0, '1,       64'd0, 1'b1, 64'd0, ST_OOB},
      '{CMD_LOAD,  SZ_WORD,   1'b1, 32'hFFFF_FFFC, 64'd0, 1'b1, 64'd0, ST_OOB},
      '{CMD_STORE, SZ_HALF,   1'b0, 32'd4095, 64'd0, 1'b1, 64'd0, ST_OOB},
      '{CMD_LOAD,  SZ_BYTE,   1'b1, 32'd4095, 64'd0, 1'b1, '1,    ST_OK}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < PLAN_ROWS; k++) offer(plan[k]);

    for (p = 0; p < 8; p++) begin
      drain_rsp();
      idle_pct = 20;
      n_items  = 62;
      case (p)
        0: begin nb = 32'h0;          nw = 13'd4096; end
        1: begin nb = 32'hFFFF_FF00;  nw = 13'd4096; end
        2: begin nb = 32'hFFFF_FFFF;  nw = 13'd1; end
        3: begin nb = $urandom;       nw = 13'd0; n_items = 20; end
        4: begin nb = $urandom;       nw = 13'd8191; end
        5: begin nb = $urandom;       nw = 13'($urandom_range(1, 4096)); idle_pct = 0; end
        6: begin nb = 32'h8000_0000;  nw = 13'd8; end
        default: begin nb = $urandom; nw = 13'($urandom_range(0, 4096)); end
      endcase
      set_window(nb, nw);
      if (p == 6) hold_rsp_req = 1'b1;
      for (k = 0; k < n_items; k++) begin
        row.cmd         = bdma_cmd_t'($urandom_range(0, 1));
        row.size        = bdma_size_t'($urandom_range(0, 3));
        row.sext        = 1'($urandom_range(0, 1));
        row.addr        = pick_address(row.size);
        row.data        = {$urandom, $urandom};
        row.typed       = 1'b0;
        row.want_data   = '0;
        row.want_status = ST_OK;
        offer(row);
      end
    end

    drain_rsp();

    $display("covered %0d loads and %0d stores, %0d out of bounds and %0d misaligned",
             n_loads, n_stores, n_oob, n_misaligned);
    $display("over %0d window settings after reset, with one %0d-cycle response hold",
             n_settings, HOLD_CYCLES);
    if (errors == 0) begin
      $display("bounded_data_memory_access_unit test passed");
    end else begin
      $display("bounded_data_memory_access_unit test failed");
    end
    $finish;
  end

endmodule
